// File: rtl/core/peer_connection_id_table_top_assert.svh
// Assertion macros used by the checker file of the connection-ID table.
// Depends on nothing; included by the bound checker module.
`ifndef PEER_CONNECTION_ID_TABLE_TOP_ASSERT_SVH
`define PEER_CONNECTION_ID_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pct check failed");
// Next-cycle implication checked outside reset.
`define PCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pct check failed");
`endif

// File: rtl/core/pcid_pkg.sv
// Shared types and constants of the peer connection-ID table.
// Depends on nothing; used by every module in rtl/core.
`timescale 1ns / 1ps
package pcid_pkg;
  localparam int unsigned TableSlots  = 4;
  localparam int unsigned CidMaxBytes = 20;
  localparam logic [19:0] RotLimitRst = 20'd5000;
  localparam logic [19:0] CntMax      = 20'hFFFFF;

  localparam logic [2:0] ActNewId   = 3'd0;
  localparam logic [2:0] ActGet     = 3'd1;
  localparam logic [2:0] ActSetId   = 3'd2;
  localparam logic [2:0] ActSetTok  = 3'd3;
  localparam logic [2:0] ActPktSent = 3'd4;
  localparam logic [2:0] ActClose   = 3'd5;

  localparam logic [2:0] KindRetire    = 3'd0;
  localparam logic [2:0] KindTokRetire = 3'd1;
  localparam logic [2:0] KindTokAdd    = 3'd2;
  localparam logic [2:0] KindTokRemove = 3'd3;
  localparam logic [2:0] KindActive    = 3'd4;
  localparam logic [2:0] KindStatus    = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StIdConf   = 3'd1;
  localparam logic [2:0] StTokConf  = 3'd2;
  localparam logic [2:0] StIdLimit  = 3'd3;
  localparam logic [2:0] StNotFirst = 3'd4;

  typedef struct packed {
    logic [61:0]  seq;
    logic [4:0]   len;
    logic [63:0]  w0;
    logic [63:0]  w1;
    logic [31:0]  w2;
    logic [63:0]  th;
    logic [63:0]  tl;
  } entry_t;

  // Cell control: shift toward front, insert at position, shift back.
  typedef struct packed {
    logic   pop;
    logic   ins;
    logic   [4:0] ins_pos;
    entry_t ins_data;
  } cell_ctrl_t;

  // Keep the first k bytes of a 64-bit word, byte 0 on top.
  function automatic logic [63:0] keep64(logic [63:0] w, logic [4:0] k);
    logic [63:0] m;
    m = '1;
    if (k >= 5'd8) return w;
    m = m << {k[2:0] == 3'd0 ? 7'd64 : 7'(8 * (8 - k[2:0]))};
    if (k == 5'd0) return '0;
    return w & m;
  endfunction

  function automatic logic [31:0] keep32(logic [31:0] w, logic [4:0] k);
    logic [31:0] m;
    m = '1;
    if (k >= 5'd4) return w;
    if (k == 5'd0) return '0;
    m = m << (6'(8 * (4 - k[2:0])));
    return w & m;
  endfunction
endpackage

// File: rtl/core/pcid_cell.sv
// One slot of the sorted table: holds an entry and its valid flag.
// Depends on pcid_pkg; chained by pcid_chain.
`timescale 1ns / 1ps
module pcid_cell #(
  parameter int unsigned Index = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcid_pkg::cell_ctrl_t ctrl_i,
  input  pcid_pkg::entry_t   prev_i,
  input  logic               prev_vld_i,
  input  pcid_pkg::entry_t   next_i,
  input  logic               next_vld_i,
  output pcid_pkg::entry_t   ent_o,
  output logic               vld_o
);
  pcid_pkg::entry_t ent_q, ent_d;
  logic vld_q, vld_d;

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (ctrl_i.pop) begin
      ent_d = next_i;
      vld_d = next_vld_i;
    end else if (ctrl_i.ins) begin
      if (5'(Index) == ctrl_i.ins_pos) begin
        ent_d = ctrl_i.ins_data;
        vld_d = 1'b1;
      end else if (5'(Index) > ctrl_i.ins_pos) begin
        ent_d = prev_i;
        vld_d = prev_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;
endmodule

// File: rtl/core/pcid_chain.sv
// Row of table cells; entries move one slot per pop or insert.
// Depends on pcid_pkg and pcid_cell.
`timescale 1ns / 1ps
module pcid_chain #(
  parameter int unsigned Slots = pcid_pkg::TableSlots
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcid_pkg::cell_ctrl_t ctrl_i,
  output pcid_pkg::entry_t     ent_o [Slots],
  output logic [Slots-1:0]     vld_o
);
  pcid_pkg::entry_t ents [Slots];
  logic [Slots-1:0] vlds;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    pcid_pkg::entry_t pv, nx;
    logic pvv, nxv;
    if (g == 0) begin : g_first
      assign pv = '0;
      assign pvv = 1'b0;
    end else begin : g_mid
      assign pv = ents[g-1];
      assign pvv = vlds[g-1];
    end
    if (g == Slots - 1) begin : g_last
      assign nx = '0;
      assign nxv = 1'b0;
    end else begin : g_nl
      assign nx = ents[g+1];
      assign nxv = vlds[g+1];
    end
    pcid_cell #(.Index(g)) u_cell (
      .clk_i, .rst_ni, .ctrl_i,
      .prev_i(pv), .prev_vld_i(pvv), .next_i(nx), .next_vld_i(nxv),
      .ent_o(ents[g]), .vld_o(vlds[g])
    );
  end

  assign ent_o = ents;
  assign vld_o = vlds;
endmodule

// File: rtl/core/peer_connection_id_table_top.sv
// Peer connection-ID table: busy drops while last is shown, so the next request
// can be taken at the edge that takes the last result. Results may have idle
// cycles between them.
// Sync retires pop one table cell per cycle. Reset clears all control state
// and the valid flags of the cells; the rotation limit register resets to 5000.
`timescale 1ns / 1ps
module peer_connection_id_table_top #(
  parameter int unsigned Slots = pcid_pkg::TableSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [61:0] seq_num_i,
  input  logic [61:0] retire_prior_to_i,
  input  logic [4:0]  cid_len_i,
  input  logic [63:0] cid_word0_i,
  input  logic [63:0] cid_word1_i,
  input  logic [31:0] cid_word2_i,
  input  logic [63:0] token_high_i,
  input  logic [63:0] token_low_i,
  output logic        valid_o,
  output logic [2:0]  kind_o,
  output logic [61:0] out_seq_o,
  output logic [4:0]  out_cid_len_o,
  output logic [63:0] out_cid_word0_o,
  output logic [63:0] out_cid_word1_o,
  output logic [31:0] out_cid_word2_o,
  output logic [63:0] out_token_high_o,
  output logic [63:0] out_token_low_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SYNC   = 9'b000000010,
    S_LOOK   = 9'b000000100,
    S_ROT0   = 9'b000001000,
    S_ROT1   = 9'b000010000,
    S_ROT2   = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_GETOUT = 9'b010000000,
    S_TOKADD = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [19:0] rot_lim_q;
  logic [61:0] cur_seq_q, max_ret_q;
  logic [4:0]  cur_len_q;
  logic [63:0] cur_w0_q, cur_w1_q, cur_th_q, cur_tl_q;
  logic [31:0] cur_w2_q;
  logic        tok_q;
  logic [19:0] pkts_q, act_lim_q;
  logic [2:0]  st_q;
  logic        get_q;
  pcid_pkg::entry_t req_q;
  logic [61:0] prior_q;

  pcid_pkg::cell_ctrl_t ctrl;
  pcid_pkg::entry_t ents [Slots];
  logic [Slots-1:0] vld;

  pcid_chain #(.Slots(Slots)) u_chain (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .ent_o(ents), .vld_o(vld)
  );

  logic [CntW-1:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < Slots; i++) cnt = cnt + CntW'(vld[i]);
  end

  // Insert position and duplicate match, per cell in parallel.
  logic [4:0] pos;
  logic       dup_hit, dup_id, dup_tok;
  always_comb begin
    pos = 5'(cnt);
    dup_hit = 1'b0; dup_id = 1'b0; dup_tok = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (vld[i] && !(ents[i].seq < req_q.seq)) pos = 5'(i);
    end
    for (int i = 0; i < Slots; i++) begin
      if (vld[i] && ents[i].seq == req_q.seq) begin
        dup_hit = 1'b1;
        dup_id = ents[i].len != req_q.len || ents[i].w0 != req_q.w0 ||
                 ents[i].w1 != req_q.w1 || ents[i].w2 != req_q.w2;
        dup_tok = ents[i].th != req_q.th || ents[i].tl != req_q.tl;
      end
    end
  end

  // Input masking of the connection ID.
  logic [4:0] in_len;
  pcid_pkg::entry_t in_ent;
  always_comb begin
    in_len = (cid_len_i > 5'(pcid_pkg::CidMaxBytes)) ? 5'(pcid_pkg::CidMaxBytes) : cid_len_i;
    in_ent.seq = seq_num_i;
    in_ent.len = in_len;
    in_ent.w0  = pcid_pkg::keep64(cid_word0_i, in_len);
    in_ent.w1  = pcid_pkg::keep64(cid_word1_i, (in_len > 5'd8) ? in_len - 5'd8 : 5'd0);
    in_ent.w2  = pcid_pkg::keep32(cid_word2_i, (in_len > 5'd16) ? in_len - 5'd16 : 5'd0);
    in_ent.th  = token_high_i;
    in_ent.tl  = token_low_i;
  end

  logic acc;
  assign acc = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  logic        ov, ol;
  logic [2:0]  ok, ost;
  logic [61:0] os;
  logic [63:0] oth, otl;
  logic        ocid;

  logic [61:0] cur_seq_d, max_ret_d;
  logic        take_front;
  logic        rot_ok;
  assign rot_ok = vld[0];

  always_comb begin
    state_d = state_q;
    ctrl = '0;
    ctrl.ins_data = req_q;
    ov = 1'b0; ol = 1'b0; ok = pcid_pkg::KindStatus; ost = pcid_pkg::StOk;
    os = '0; oth = '0; otl = '0; ocid = 1'b0;
    take_front = 1'b0;
    cur_seq_d = cur_seq_q;
    max_ret_d = max_ret_q;
    case (state_q)
      S_SYNC: begin
        if (vld[0] && ents[0].seq <= prior_q) begin
          ov = 1'b1; ok = pcid_pkg::KindRetire; os = ents[0].seq;
          ctrl.pop = 1'b1;
        end else begin
          max_ret_d = prior_q;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (req_q.seq == cur_seq_q) begin
          ov = 1'b1; ol = 1'b1; state_d = S_IDLE;
        end else if (dup_hit && dup_id) begin
          ov = 1'b1; ol = 1'b1; ost = pcid_pkg::StIdConf; state_d = S_IDLE;
        end else if (dup_hit && dup_tok) begin
          ov = 1'b1; ol = 1'b1; ost = pcid_pkg::StTokConf; state_d = S_IDLE;
        end else begin
          if (!dup_hit) begin
            if (32'(cnt) >= Slots) begin
              state_d = S_FIN;
            end else begin
              ctrl.ins = 1'b1; ctrl.ins_pos = pos;
              state_d = S_FIN;
            end
          end else begin
            state_d = S_FIN;
          end
          if (cur_seq_q < prior_q) state_d = S_ROT0;
        end
      end
      S_ROT0: begin
        if (!rot_ok) begin
          state_d = get_q ? S_GETOUT : S_FIN;
        end else begin
          ov = 1'b1; ok = pcid_pkg::KindRetire; os = cur_seq_q;
          if (max_ret_q < cur_seq_q) max_ret_d = cur_seq_q;
          state_d = tok_q ? S_ROT1 : S_ROT2;
        end
      end
      S_ROT1: begin
        ov = 1'b1; ok = pcid_pkg::KindTokRetire; oth = cur_th_q; otl = cur_tl_q;
        state_d = S_ROT2;
      end
      S_ROT2: begin
        take_front = 1'b1;
        ctrl.pop = 1'b1;
        state_d = S_TOKADD;
      end
      S_TOKADD: begin
        ov = 1'b1; ok = pcid_pkg::KindTokAdd; oth = cur_th_q; otl = cur_tl_q;
        state_d = get_q ? S_GETOUT : S_FIN;
      end
      S_FIN: begin
        ov = 1'b1; ol = 1'b1; ost = st_q; state_d = S_IDLE;
      end
      S_GETOUT: begin
        ov = 1'b1; ol = 1'b1; ok = pcid_pkg::KindActive; os = cur_seq_q; ocid = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rot_lim_q <= pcid_pkg::RotLimitRst;
      cur_seq_q <= '0; max_ret_q <= '0; cur_len_q <= '0;
      cur_w0_q <= '0; cur_w1_q <= '0; cur_w2_q <= '0;
      cur_th_q <= '0; cur_tl_q <= '0; tok_q <= 1'b0;
      pkts_q <= '0; act_lim_q <= '0;
      st_q <= '0; get_q <= 1'b0;
      valid_o <= 1'b0; last_o <= 1'b0;
      kind_o <= '0; status_o <= '0; out_seq_o <= '0;
      out_cid_len_o <= '0; out_cid_word0_o <= '0; out_cid_word1_o <= '0;
      out_cid_word2_o <= '0; out_token_high_o <= '0; out_token_low_o <= '0;
    end else begin
      state_q <= state_d;
      max_ret_q <= max_ret_d;
      if (psel && penable && pwrite && paddr == 3'd0) rot_lim_q <= pwdata[19:0];
      valid_o <= ov; last_o <= ov && ol;
      kind_o <= ok; status_o <= ost; out_seq_o <= os;
      out_token_high_o <= oth; out_token_low_o <= otl;
      out_cid_len_o   <= ocid ? cur_len_q : '0;
      out_cid_word0_o <= ocid ? cur_w0_q : '0;
      out_cid_word1_o <= ocid ? cur_w1_q : '0;
      out_cid_word2_o <= ocid ? cur_w2_q : '0;
      if (state_q == S_LOOK && !dup_hit && 32'(cnt) >= Slots) st_q <= pcid_pkg::StIdLimit;
      if (take_front) begin
        cur_seq_q <= ents[0].seq; cur_len_q <= ents[0].len;
        cur_w0_q <= ents[0].w0; cur_w1_q <= ents[0].w1; cur_w2_q <= ents[0].w2;
        cur_th_q <= ents[0].th; cur_tl_q <= ents[0].tl; tok_q <= 1'b1;
        pkts_q <= '0; act_lim_q <= rot_lim_q;
      end else begin
        cur_seq_q <= cur_seq_d;
      end
      if (acc) begin
        st_q <= pcid_pkg::StOk; get_q <= 1'b0;
        case (action_i)
          pcid_pkg::ActNewId: begin
            if (seq_num_i < max_ret_q) begin
              valid_o <= 1'b1; kind_o <= pcid_pkg::KindRetire; out_seq_o <= seq_num_i;
              state_q <= S_FIN;
            end else if (retire_prior_to_i > max_ret_q) begin
              state_q <= S_SYNC;
            end else begin
              state_q <= S_LOOK;
            end
          end
          pcid_pkg::ActGet: begin
            get_q <= 1'b1;
            if (vld[0] && (cur_seq_q == '0 || ((32'(cnt) * 2 >= Slots) &&
                pkts_q >= act_lim_q))) state_q <= S_ROT0;
            else state_q <= S_GETOUT;
          end
          pcid_pkg::ActSetId: begin
            if (cur_seq_q != '0) st_q <= pcid_pkg::StNotFirst;
            else begin
              cur_len_q <= in_len; cur_w0_q <= in_ent.w0;
              cur_w1_q <= in_ent.w1; cur_w2_q <= in_ent.w2;
            end
            state_q <= S_FIN;
          end
          pcid_pkg::ActSetTok: begin
            if (cur_seq_q != '0) begin
              st_q <= pcid_pkg::StNotFirst; state_q <= S_FIN;
            end else begin
              cur_th_q <= token_high_i; cur_tl_q <= token_low_i; tok_q <= 1'b1;
              state_q <= S_TOKADD;
            end
          end
          pcid_pkg::ActPktSent: begin
            if (pkts_q != pcid_pkg::CntMax) pkts_q <= pkts_q + 20'd1;
            state_q <= S_FIN;
          end
          pcid_pkg::ActClose: begin
            if (tok_q) begin
              valid_o <= 1'b1; kind_o <= pcid_pkg::KindTokRemove;
              out_token_high_o <= cur_th_q; out_token_low_o <= cur_tl_q;
            end
            state_q <= S_FIN;
          end
          default: state_q <= S_FIN;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= in_ent;
      prior_q <= retire_prior_to_i;
    end
  end

  assign prdata = {12'd0, rot_lim_q};
  assign pready = 1'b1;
endmodule

// File: rtl/core/pcid_checker.sv
// Port-level checker for the connection-ID table, bound to the top level.
// Depends on peer_connection_id_table_top_assert.svh and pcid_pkg.
`timescale 1ns / 1ps
`include "peer_connection_id_table_top_assert.svh"
module pcid_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       last_o,
  input logic [2:0] status_o,
  input logic [2:0] kind_o
);
  `PCT_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `PCT_ASSERT_IMP(a_last_valid, clk_i, rst_ni, last_o, valid_o)
  `PCT_ASSERT_IMP(a_status_zero, clk_i, rst_ni, valid_o && kind_o != pcid_pkg::KindStatus, status_o == pcid_pkg::StOk)
  `PCT_ASSERT_IMP(a_last_idle, clk_i, rst_ni, last_o, !busy_o)
endmodule

bind peer_connection_id_table_top pcid_port_checker u_pcid_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .valid_o, .last_o, .status_o, .kind_o
);
